@@ src/jbig2_segment_header_parser_assert.svh @@
// Assertion macros used by the checker file of the segment header parser.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef JBIG2_SEGMENT_HEADER_PARSER_ASSERT_SVH
`define JBIG2_SEGMENT_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JSHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/jbig2shp_pkg.sv @@
// Types, constants and the segment type table of the JBIG2 segment header parser.
// No dependencies; used by the parser core, the top level and the checker.
`timescale 1ns / 1ps

package jbig2shp_pkg;

  // Record kinds on the result channel
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_REF    = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_e;

  localparam logic [31:0] REF_BYTE_MAX   = 32'd256;
  localparam logic [31:0] REF_HALF_MAX   = 32'd65536;
  localparam logic [31:0] LENGTH_OPEN    = 32'hffff_ffff;
  localparam logic [2:0]  REFCNT_ESCAPE  = 3'd7;
  localparam int unsigned FLAG_PAGE_WIDE = 6;
  localparam logic [29:0] RETAIN_BIAS    = 30'd9;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] seg_number;
    logic [5:0]  seg_type;
    logic [31:0] page_number;
    logic [31:0] data_length;
    logic        length_unknown;
    logic        type_unknown;
    logic [28:0] ref_total;
    logic [31:0] ref_value;
    logic [7:0]  payload_byte;
    logic        last;
  } out_rec_t;

  // True for segment types that the standard does not define
  function automatic logic type_is_unknown(input logic [5:0] seg_type);
    logic unknown;
    unknown = 1'b1;
    case (seg_type) inside
      6'd0, 6'd4, 6'd6, 6'd7, 6'd16, 6'd20, 6'd22, 6'd23, 6'd36, 6'd38, 6'd39,
      6'd40, 6'd42, 6'd43, 6'd48, 6'd49, 6'd50, 6'd51, 6'd52, 6'd53, 6'd62: unknown = 1'b0;
      default: unknown = 1'b1;
    endcase
    return unknown;
  endfunction

endpackage

@@ src/jbig2shp_stream_if.sv @@
// Valid/ready stream interface carrying one payload item per transfer.
// Payload type is set per instance; depends on nothing else.
`timescale 1ns / 1ps

interface jbig2shp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/jbig2shp_core.sv @@
// Segment header state machine: takes one stream byte per step and forms at most one record.
// Depends on jbig2shp_pkg.
`timescale 1ns / 1ps

module jbig2shp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  jbig2shp_pkg::in_item_t item_i,
  output logic                  res_valid_o,
  output jbig2shp_pkg::out_rec_t res_o
);

  typedef enum logic [3:0] {
    PH_SEGNUM  = 4'd0,
    PH_FLAGS   = 4'd1,
    PH_REFCNT  = 4'd2,
    PH_REFLONG = 4'd3,
    PH_RETAIN  = 4'd4,
    PH_REFS    = 4'd5,
    PH_PAGE    = 4'd6,
    PH_LENGTH  = 4'd7,
    PH_DATA    = 4'd8,
    PH_OPEN    = 4'd9
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] seg_num_q, seg_num_d;
  logic [7:0]  flags_q, flags_d;
  logic [28:0] refs_exp_q, refs_exp_d;
  logic [28:0] refs_done_q, refs_done_d;
  logic [26:0] skip_q, skip_d;
  logic [31:0] page_q, page_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] seg_len_q, seg_len_d;
  logic        len_open_q, len_open_d;

  logic [7:0]  in_byte;
  logic [31:0] acc_shift;
  logic [1:0]  last_idx;
  logic        field_done;
  logic [28:0] refs_long;
  logic [29:0] retain_sum;
  logic [28:0] refs_done_inc;
  logic [31:0] remain_dec;
  logic [5:0]  cur_type;

  assign in_byte       = item_i.in_byte;
  assign acc_shift     = {acc_q[23:0], in_byte};
  assign field_done    = (idx_q >= last_idx);
  assign refs_long     = acc_shift[28:0];
  assign retain_sum    = {1'b0, refs_long} + jbig2shp_pkg::RETAIN_BIAS;
  assign refs_done_inc = refs_done_q + 29'd1;
  assign remain_dec    = remain_q - 32'd1;
  assign cur_type      = flags_q[5:0];

  // Last byte position of the field that the current phase is collecting
  always_comb begin
    last_idx = 2'd0;
    case (phase_q)
      PH_SEGNUM, PH_LENGTH: last_idx = 2'd3;
      PH_REFLONG:           last_idx = 2'd2;
      PH_REFS: begin
        if (seg_num_q <= jbig2shp_pkg::REF_BYTE_MAX) begin
          last_idx = 2'd0;
        end else if (seg_num_q <= jbig2shp_pkg::REF_HALF_MAX) begin
          last_idx = 2'd1;
        end else begin
          last_idx = 2'd3;
        end
      end
      PH_PAGE: last_idx = flags_q[jbig2shp_pkg::FLAG_PAGE_WIDE] ? 2'd3 : 2'd0;
      default: last_idx = 2'd0;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    seg_num_d   = seg_num_q;
    flags_d     = flags_q;
    refs_exp_d  = refs_exp_q;
    refs_done_d = refs_done_q;
    skip_d      = skip_q;
    page_d      = page_q;
    remain_d    = remain_q;
    seg_len_d   = seg_len_q;
    len_open_d  = len_open_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    // Fields common to referred, header and data records
    res_o.seg_number   = seg_num_q;
    res_o.seg_type     = cur_type;
    res_o.type_unknown = jbig2shp_pkg::type_is_unknown(cur_type);
    res_o.ref_total    = refs_exp_q;

    if (step_i && item_i.end_of_stream) begin
      if (phase_q != PH_SEGNUM && phase_q != PH_OPEN) begin
        res_valid_o = 1'b1;
      end
      res_o            = '0;
      res_o.kind       = jbig2shp_pkg::KIND_TRUNC;
      res_o.seg_number = seg_num_q;
      phase_d     = PH_SEGNUM;
      idx_d       = '0;
      acc_d       = '0;
      seg_num_d   = '0;
      flags_d     = '0;
      refs_exp_d  = '0;
      refs_done_d = '0;
      skip_d      = '0;
      page_d      = '0;
      remain_d    = '0;
      seg_len_d   = '0;
      len_open_d  = 1'b0;
    end else if (step_i) begin
      // Advance the byte position within a multi-byte field
      if (phase_q == PH_SEGNUM || phase_q == PH_REFLONG || phase_q == PH_REFS ||
          phase_q == PH_PAGE || phase_q == PH_LENGTH) begin
        acc_d = acc_shift;
        idx_d = field_done ? 2'd0 : idx_q + 2'd1;
      end
      unique case (phase_q)
        PH_SEGNUM: begin
          if (field_done) begin
            seg_num_d  = acc_shift;
            acc_d      = '0;
            flags_d    = '0;
            refs_exp_d = '0;
            page_d     = '0;
            seg_len_d  = '0;
            len_open_d = 1'b0;
            phase_d    = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flags_d = in_byte;
          phase_d = PH_REFCNT;
        end
        PH_REFCNT: begin
          idx_d = '0;
          if (in_byte[7:5] == jbig2shp_pkg::REFCNT_ESCAPE) begin
            acc_d   = {27'd0, in_byte[4:0]};
            phase_d = PH_REFLONG;
          end else begin
            refs_exp_d  = {26'd0, in_byte[7:5]};
            refs_done_d = '0;
            acc_d       = '0;
            phase_d     = (in_byte[7:5] == 3'd0) ? PH_PAGE : PH_REFS;
          end
        end
        PH_REFLONG: begin
          if (field_done) begin
            refs_exp_d = refs_long;
            skip_d     = retain_sum[29:3];
            acc_d      = '0;
            phase_d    = PH_RETAIN;
          end
        end
        PH_RETAIN: begin
          skip_d = skip_q - 27'd1;
          if (skip_q == 27'd1) begin
            refs_done_d = '0;
            acc_d       = '0;
            idx_d       = '0;
            phase_d     = (refs_exp_q == 29'd0) ? PH_PAGE : PH_REFS;
          end
        end
        PH_REFS: begin
          if (field_done) begin
            res_valid_o     = 1'b1;
            res_o.kind      = jbig2shp_pkg::KIND_REF;
            res_o.ref_value = acc_shift;
            acc_d           = '0;
            refs_done_d     = refs_done_inc;
            if (refs_done_inc >= refs_exp_q) begin
              phase_d = PH_PAGE;
            end
          end
        end
        PH_PAGE: begin
          if (field_done) begin
            page_d  = acc_shift;
            acc_d   = '0;
            phase_d = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (field_done) begin
            seg_len_d  = acc_shift;
            acc_d      = '0;
            len_open_d = (acc_shift == jbig2shp_pkg::LENGTH_OPEN);
            res_valid_o          = 1'b1;
            res_o.kind           = jbig2shp_pkg::KIND_HEADER;
            res_o.page_number    = page_q;
            res_o.data_length    = acc_shift;
            res_o.length_unknown = (acc_shift == jbig2shp_pkg::LENGTH_OPEN);
            if (acc_shift == jbig2shp_pkg::LENGTH_OPEN) begin
              phase_d = PH_OPEN;
            end else if (acc_shift == 32'd0) begin
              phase_d = PH_SEGNUM;
            end else begin
              remain_d = acc_shift;
              phase_d  = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          remain_d             = remain_dec;
          res_valid_o          = 1'b1;
          res_o.kind           = jbig2shp_pkg::KIND_DATA;
          res_o.page_number    = page_q;
          res_o.data_length    = seg_len_q;
          res_o.length_unknown = len_open_q;
          res_o.payload_byte   = in_byte;
          res_o.last           = (remain_dec == 32'd0);
          if (remain_dec == 32'd0) begin
            phase_d = PH_SEGNUM;
          end
        end
        PH_OPEN: begin
          res_valid_o          = 1'b1;
          res_o.kind           = jbig2shp_pkg::KIND_DATA;
          res_o.page_number    = page_q;
          res_o.data_length    = seg_len_q;
          res_o.length_unknown = len_open_q;
          res_o.payload_byte   = in_byte;
        end
        default: begin
          // Unused phase codes: fall back to the reset state
          phase_d     = PH_SEGNUM;
          idx_d       = '0;
          acc_d       = '0;
          seg_num_d   = '0;
          flags_d     = '0;
          refs_exp_d  = '0;
          refs_done_d = '0;
          skip_d      = '0;
          page_d      = '0;
          remain_d    = '0;
          seg_len_d   = '0;
          len_open_d  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEGNUM;
      idx_q       <= '0;
      acc_q       <= '0;
      seg_num_q   <= '0;
      flags_q     <= '0;
      refs_exp_q  <= '0;
      refs_done_q <= '0;
      skip_q      <= '0;
      page_q      <= '0;
      remain_q    <= '0;
      seg_len_q   <= '0;
      len_open_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      seg_num_q   <= seg_num_d;
      flags_q     <= flags_d;
      refs_exp_q  <= refs_exp_d;
      refs_done_q <= refs_done_d;
      skip_q      <= skip_d;
      page_q      <= page_d;
      remain_q    <= remain_d;
      seg_len_q   <= seg_len_d;
      len_open_q  <= len_open_d;
    end
  end

endmodule

@@ src/jbig2_segment_header_parser.sv @@
// Top level of the JBIG2 segment header parser: stream handshake and result register.
// Depends on jbig2shp_pkg, jbig2shp_stream_if and jbig2shp_core.
//
//   channel    dir   payload                                   transfer when
//   stream_i   in    in_item_t (in_byte, end_of_stream)         valid && ready
//   record_o   out   out_rec_t (kind, seg_number, ... , last)   valid && ready
//
// One byte is taken per cycle when not stalled; any record it forms is registered.
// The state update and the record are formed combinationally from the parser state.
// The result register is the only buffer: a new byte is taken while the held record
// leaves in the same cycle, or while no record is held.
// Reset (rst_ni low, asynchronous) returns to waiting for a segment number.

`timescale 1ns / 1ps

module jbig2_segment_header_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  jbig2shp_stream_if.sink    stream_i,
  jbig2shp_stream_if.source  record_o
);

  logic                   in_ready;
  logic                   step;
  logic                   res_valid;
  jbig2shp_pkg::out_rec_t res;
  logic                   out_valid_q;
  jbig2shp_pkg::out_rec_t out_rec_q;

  assign in_ready = !out_valid_q || record_o.ready;
  assign step     = stream_i.valid && in_ready;

  jbig2shp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (stream_i.payload),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load a new record whenever the register is free or emptying this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && res_valid) begin
      out_rec_q <= res;
    end
  end

  assign stream_i.ready   = in_ready;
  assign record_o.valid   = out_valid_q;
  assign record_o.payload = out_rec_q;

endmodule

@@ src/jbig2shp_checker.sv @@
// Port-level checks of the segment header parser, attached to the top level by bind.
// Depends on jbig2shp_pkg and the assertion macros header.
`timescale 1ns / 1ps

`include "jbig2_segment_header_parser_assert.svh"

module jbig2shp_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input jbig2shp_pkg::out_rec_t out_rec_i
);

  logic out_stall;
  logic out_free;
  logic in_idle;
  logic last_seen;
  logic last_ok;
  logic trunc_seen;
  logic trunc_ok;

  assign out_stall  = out_valid_i && !out_ready_i;
  assign out_free   = !out_valid_i || out_ready_i;
  assign in_idle    = in_ready_i && !in_valid_i;
  assign last_seen  = out_valid_i && out_rec_i.last;
  assign last_ok    = (out_rec_i.kind == jbig2shp_pkg::KIND_DATA) && !out_rec_i.length_unknown;
  assign trunc_seen = out_valid_i && (out_rec_i.kind == jbig2shp_pkg::KIND_TRUNC);
  assign trunc_ok   = (out_rec_i.seg_type == 6'd0) && (out_rec_i.ref_total == 29'd0) &&
                      (out_rec_i.data_length == 32'd0);

  `JSHP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i, "record dropped while stalled")
  `JSHP_ASSERT_NOW(a_in_ready_free, clk_i, rst_ni, out_free, in_ready_i, "stream stalled with free result register")
  `JSHP_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, in_idle, !out_valid_i, "record without a stream transfer")
  `JSHP_ASSERT_NOW(a_last_data, clk_i, rst_ni, last_seen, last_ok, "last mark outside known-length data")
  `JSHP_ASSERT_NOW(a_trunc_clear, clk_i, rst_ni, trunc_seen, trunc_ok, "truncation record carries header fields")

endmodule

bind jbig2_segment_header_parser jbig2shp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (stream_i.valid),
  .in_ready_i  (stream_i.ready),
  .out_valid_i (record_o.valid),
  .out_ready_i (record_o.ready),
  .out_rec_i   (record_o.payload)
);
